/* rtl/core/counting_chained_hash_table_defines.svh */
// Assertion macros used by the counting chained hash table checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef COUNTING_CHAINED_HASH_TABLE_DEFINES_SVH
`define COUNTING_CHAINED_HASH_TABLE_DEFINES_SVH

// Property checked on every clock outside reset.
`define CCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked on every clock outside reset.
`define CCH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cch_pkg.sv */
// Shared types and codes of the counting chained hash table.
// No dependencies.
package cch_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 24;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] STATUS_NEW     = 3'd0;
  localparam logic [2:0] STATUS_INC     = 3'd1;
  localparam logic [2:0] STATUS_FOUND   = 3'd2;
  localparam logic [2:0] STATUS_ABSENT  = 3'd3;
  localparam logic [2:0] STATUS_FULL    = 3'd4;
  localparam logic [2:0] STATUS_CLEARED = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COUNT_W-1:0] count;
  } out_res_t;

endpackage

/* rtl/core/counting_chained_hash_table.sv */
// Counting hash table with chaining over a fixed node pool.
// Depends on cch_pkg.

// One request at a time. An insert or lookup reads the bucket head and then
// the chain entries from the pool memory (one per cycle, each read addressed
// by the link in the previous entry); a non power of two BUCKETS first takes
// the key modulo, which reduces the key magnitude four bits per cycle. A clear
// sweeps the head memory one bucket per cycle, and the same sweep runs after
// reset before the first request is taken.
// Results sit in an output register, so a new request is taken while the
// previous result waits.
module counting_chained_hash_table #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cch_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output cch_pkg::out_res_t out_res
);

  import cch_pkg::*;

  localparam int  BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  EW     = $clog2(ENTRIES);
  localparam int  UW     = $clog2(ENTRIES + 1);
  localparam bit  POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int  DIG_W  = 4;
  localparam int  DIGITS = KEY_W / DIG_W;

  localparam logic [BW-1:0] BKT_TOP  = BW'(BUCKETS);
  localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);
  localparam logic [UW-1:0] POOL_CAP = UW'(ENTRIES);

  typedef struct packed {
    logic          valid;
    logic [EW-1:0] idx;
  } head_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               lvalid;
    logic [EW-1:0]      link;
  } pool_word_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_HWAIT,
    S_WALK,
    S_DONE
  } state_t;

  // Memories
  head_word_t head_mem [BUCKETS];
  pool_word_t pool_mem [ENTRIES];

  logic       head_re, head_we;
  logic [BW-1:0] head_ra, head_wa;
  head_word_t head_wd, head_q;

  logic       pool_re, pool_we;
  logic [EW-1:0] pool_ra, pool_wa;
  pool_word_t pool_wd, pool_q;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_q <= head_mem[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (pool_re) begin
      pool_q <= pool_mem[pool_ra];
    end
  end

  // Control and datapath registers
  state_t           state_r, state_nxt;
  logic [BW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             clr_req_r, clr_req_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, out_res_nxt;
  out_res_t         res_r, res_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             neg_r, neg_nxt;
  logic [KEY_W-1:0] mag_r, mag_nxt;
  logic [BW-1:0]    rem_r, rem_nxt;
  logic [2:0]       div_cnt_r, div_cnt_nxt;
  logic [BW-1:0]    bucket_r, bucket_nxt;
  head_word_t       head_link_r, head_link_nxt;
  logic [EW-1:0]    cur_idx_r, cur_idx_nxt;

  logic [BW+DIG_W-1:0] trial;
  logic [BW+DIG_W-1:0] trial_red;
  logic [BW-1:0]       rem_step;
  logic [BW-1:0]       bucket_fix;
  logic                hit, miss;
  head_word_t          miss_head;
  logic [COUNT_W-1:0]  cnt_inc;

  assign trial = {rem_r, mag_r[KEY_W-1 -: DIG_W]};

  // Reduce by the largest constant multiple of BUCKETS that fits
  always_comb begin
    trial_red = trial;
    for (int j = 1; j < (1 << DIG_W); j++) begin
      if (trial >= (BW + DIG_W)'(j * BUCKETS)) begin
        trial_red = trial - (BW + DIG_W)'(j * BUCKETS);
      end
    end
  end

  assign rem_step   = trial_red[BW-1:0];
  assign bucket_fix = (neg_r && (rem_step != '0)) ? BW'(BKT_TOP - rem_step) : rem_step;
  assign miss_head  = (state_r == S_HWAIT) ? head_q : head_link_r;
  assign cnt_inc    = (pool_q.count == COUNT_MAX) ? COUNT_MAX : pool_q.count + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    clr_req_nxt   = clr_req_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    bucket_nxt    = bucket_r;
    head_link_nxt = head_link_r;
    cur_idx_nxt   = cur_idx_r;
    head_re       = 1'b0;
    head_ra       = '0;
    head_we       = 1'b0;
    head_wa       = '0;
    head_wd       = '0;
    pool_re       = 1'b0;
    pool_ra       = '0;
    pool_we       = 1'b0;
    pool_wa       = '0;
    pool_wd       = '0;
    hit           = 1'b0;
    miss          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        head_we     = 1'b1;
        head_wa     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == BKT_LAST) begin
          clr_idx_nxt = '0;
          clr_req_nxt = 1'b0;
          if (clr_req_r) begin
            res_nxt   = '{status: STATUS_CLEARED, count: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_req.func;
          key_nxt     = in_req.key;
          neg_nxt     = in_req.key[KEY_W-1];
          mag_nxt     = in_req.key[KEY_W-1] ? (~in_req.key + 1'b1) : in_req.key;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          case (in_req.func)
            FUNC_INSERT, FUNC_LOOKUP: begin
              if (POW2) begin
                // Two's complement low bits already give the non-negative bucket
                bucket_nxt = in_req.key[BW-1:0];
                head_re    = 1'b1;
                head_ra    = in_req.key[BW-1:0];
                state_nxt  = S_HWAIT;
              end else begin
                state_nxt = S_DIV;
              end
            end
            FUNC_CLEAR: begin
              used_nxt    = '0;
              clr_req_nxt = 1'b1;
              state_nxt   = S_INIT;
            end
            default: begin
              res_nxt   = '{status: STATUS_ABSENT, count: '0};
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        // Remainder of the key magnitude, four bits per cycle
        mag_nxt     = {mag_r[KEY_W-DIG_W-1:0], {DIG_W{1'b0}}};
        rem_nxt     = rem_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == 3'(DIGITS - 1)) begin
          bucket_nxt = bucket_fix;
          head_re    = 1'b1;
          head_ra    = bucket_fix;
          state_nxt  = S_HWAIT;
        end
      end
      S_HWAIT: begin
        head_link_nxt = head_q;
        if (head_q.valid) begin
          pool_re     = 1'b1;
          pool_ra     = head_q.idx;
          cur_idx_nxt = head_q.idx;
          state_nxt   = S_WALK;
        end else begin
          miss = 1'b1;
        end
      end
      S_WALK: begin
        if (pool_q.key == key_r) begin
          hit = 1'b1;
        end else if (pool_q.lvalid) begin
          pool_re     = 1'b1;
          pool_ra     = pool_q.link;
          cur_idx_nxt = pool_q.link;
        end else begin
          miss = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (hit) begin
      state_nxt = S_DONE;
      if (func_r == FUNC_INSERT) begin
        pool_we       = 1'b1;
        pool_wa       = cur_idx_r;
        pool_wd       = pool_q;
        pool_wd.count = cnt_inc;
        res_nxt       = '{status: STATUS_INC, count: cnt_inc};
      end else begin
        res_nxt = '{status: STATUS_FOUND, count: pool_q.count};
      end
    end

    if (miss) begin
      state_nxt = S_DONE;
      if (func_r != FUNC_INSERT) begin
        res_nxt = '{status: STATUS_ABSENT, count: '0};
      end else if (used_r >= POOL_CAP) begin
        res_nxt = '{status: STATUS_FULL, count: '0};
      end else begin
        // Link the new node ahead of the old chain head
        pool_we        = 1'b1;
        pool_wa        = used_r[EW-1:0];
        pool_wd.key    = key_r;
        pool_wd.count  = COUNT_W'(1);
        pool_wd.lvalid = miss_head.valid;
        pool_wd.link   = miss_head.idx;
        head_we        = 1'b1;
        head_wa        = bucket_r;
        head_wd.valid  = 1'b1;
        head_wd.idx    = used_r[EW-1:0];
        used_nxt       = used_r + 1'b1;
        res_nxt        = '{status: STATUS_NEW, count: COUNT_W'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_idx_r   <= '0;
      clr_req_r   <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_req_r   <= clr_req_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r   <= out_res_nxt;
    res_r       <= res_nxt;
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    bucket_r    <= bucket_nxt;
    head_link_r <= head_link_nxt;
    cur_idx_r   <= cur_idx_nxt;
  end

endmodule

/* rtl/core/cch_checker.sv */
// Port-level checks of the counting chained hash table, bound to the top level.
// Depends on cch_pkg and counting_chained_hash_table_defines.svh.
`include "counting_chained_hash_table_defines.svh"

module cch_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input cch_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input cch_pkg::out_res_t out_res
);

  import cch_pkg::*;

  `CCH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_res), "result dropped or changed while stalled")
  `CCH_ASSERT_IMPLY(a_zero_count, out_valid && (out_res.status == STATUS_ABSENT || out_res.status == STATUS_FULL || out_res.status == STATUS_CLEARED), out_res.count == '0, "nonzero count on absent, full or cleared")
  `CCH_ASSERT_IMPLY(a_new_one, out_valid && out_res.status == STATUS_NEW, out_res.count == COUNT_W'(1), "new entry count is not one")
  `CCH_ASSERT_IMPLY(a_hit_nonzero, out_valid && (out_res.status == STATUS_INC || out_res.status == STATUS_FOUND), out_res.count != '0, "existing entry reports zero count")

endmodule

bind counting_chained_hash_table cch_checker u_cch_checker (.*);
